### src/b2da_pkg.sv
// Shared constants, types and helpers for the binary to decimal ASCII converter.
// No dependencies.
package b2da_pkg;

    localparam int VALUE_W            = 64;
    localparam int DEFAULT_VALUE_BITS = 64;
    localparam int CHAR_W             = 6;
    localparam int BCD_W              = 4;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // decimal digits needed for 2^bits - 1: floor(bits * log10(2)) + 1
    function automatic int num_digits(input int bits);
        num_digits = ((bits * 1233) >> 12) + 1;
    endfunction

    typedef struct packed {
        logic clear;
        logic dabble;
        logic bit_in;
        logic digit_shift;
    } bcd_ctrl_t;

endpackage

### src/binary_to_decimal_ascii_core.sv
// A request is converted by the bit-serial double-dabble loop, then the BCD digits are
// unloaded most significant first, leading zeros dropped; no new request is taken until
// the last digit has entered the output register.
// The next request is taken while the final digit still waits in the output register.
// Reset (rst_n, async, active low) clears the sequencer and the output valid.
// Top level: sequencer, binary shift register and output register; uses b2da_pkg and b2da_bcd_shift.
module binary_to_decimal_ascii_core #(
    parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          value_valid,
    output logic                          value_stall,
    input  logic [b2da_pkg::VALUE_W-1:0]  value,
    output logic                          digit_valid,
    input  logic                          digit_stall,
    output logic [b2da_pkg::CHAR_W-1:0]   digit_char,
    output logic                          last
);

    localparam int DIGITS = b2da_pkg::num_digits(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int REM_W  = $clog2(DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic                         started_reg, started_next;
    logic [VALUE_BITS-1:0]        bin_reg, bin_next;
    logic                         out_valid_reg, out_valid_next;
    logic [b2da_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                         last_reg, last_next;
    logic [b2da_pkg::BCD_W-1:0]   top_digit;
    b2da_pkg::bcd_ctrl_t          bcd_ctrl;
    logic                         out_free;

    b2da_bcd_shift #(
        .DIGITS (DIGITS)
    ) u_bcd (
        .clk       (clk),
        .ctrl      (bcd_ctrl),
        .top_digit (top_digit)
    );

    assign out_free = !out_valid_reg || !digit_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        started_next   = started_reg;
        bin_next       = bin_reg;
        out_valid_next = out_valid_reg && digit_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        bcd_ctrl       = '0;
        bcd_ctrl.bit_in = bin_reg[VALUE_BITS-1];

        case (state_reg)
            ST_IDLE:
            begin
                if (value_valid)
                begin
                    bin_next       = value[VALUE_BITS-1:0];
                    cnt_next       = CNT_W'(VALUE_BITS);
                    bcd_ctrl.clear = 1'b1;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_ctrl.dabble = 1'b1;
                bin_next        = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next        = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    rem_next     = REM_W'(DIGITS);
                    started_next = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!started_reg && top_digit == '0 && rem_reg != REM_W'(1))
                begin
                    // drop leading zero
                    bcd_ctrl.digit_shift = 1'b1;
                    rem_next             = rem_reg - REM_W'(1);
                end
                else if (out_free)
                begin
                    bcd_ctrl.digit_shift = 1'b1;
                    rem_next             = rem_reg - REM_W'(1);
                    started_next         = 1'b1;
                    out_valid_next       = 1'b1;
                    char_next            = b2da_pkg::ASCII_ZERO
                                           + {{(b2da_pkg::CHAR_W-b2da_pkg::BCD_W){1'b0}}, top_digit};
                    last_next            = (rem_reg == REM_W'(1));
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        started_reg <= started_next;
        bin_reg     <= bin_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign value_stall = (state_reg != ST_IDLE);
    assign digit_valid = out_valid_reg;
    assign digit_char  = char_reg;
    assign last        = last_reg;

endmodule

### src/b2da_bcd_shift.sv
// BCD shift register: double-dabble adjust-and-shift, then digit-wise unload.
// Depends on b2da_pkg.
module b2da_bcd_shift #(
    parameter int DIGITS = b2da_pkg::num_digits(b2da_pkg::DEFAULT_VALUE_BITS)
) (
    input  logic                       clk,
    input  b2da_pkg::bcd_ctrl_t        ctrl,
    output logic [b2da_pkg::BCD_W-1:0] top_digit
);

    localparam int W = DIGITS * b2da_pkg::BCD_W;

    logic [W-1:0] bcd_reg;
    logic [W-1:0] bcd_next;
    logic [W-1:0] adj;

    genvar i;
    generate
        for (i = 0; i < DIGITS; i++)
        begin : g_adj
            assign adj[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W] =
                (bcd_reg[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W] >= 4'd5) ?
                bcd_reg[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W] + 4'd3 :
                bcd_reg[i*b2da_pkg::BCD_W +: b2da_pkg::BCD_W];
        end
    endgenerate

    always_comb
    begin
        bcd_next = bcd_reg;
        if (ctrl.clear)
        begin
            bcd_next = '0;
        end
        else if (ctrl.dabble)
        begin
            bcd_next = W'({adj, ctrl.bit_in});
        end
        else if (ctrl.digit_shift)
        begin
            bcd_next = {bcd_reg[W-b2da_pkg::BCD_W-1:0], {b2da_pkg::BCD_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[W-1 -: b2da_pkg::BCD_W];

endmodule

### src/b2da_checker.sv
// Port-level checks for binary_to_decimal_ascii_core, attached by bind.
// Depends on b2da_pkg.
module b2da_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         value_valid,
    input logic                         value_stall,
    input logic                         digit_valid,
    input logic                         digit_stall,
    input logic [b2da_pkg::CHAR_W-1:0]  digit_char,
    input logic                         last
);

    logic first_reg;

    // set while the next digit is the first of a number
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else if (digit_valid && !digit_stall)
        begin
            first_reg <= last;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_stall |=> digit_valid && $stable(digit_char) && $stable(last))
        else $error("digit request changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (digit_char >= b2da_pkg::ASCII_ZERO) &&
                        (digit_char <= b2da_pkg::ASCII_ZERO + 6'd9))
        else $error("digit_char outside '0'..'9'");

    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && first_reg && digit_char == b2da_pkg::ASCII_ZERO |-> last)
        else $error("leading zero emitted");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && !value_stall |=> value_stall)
        else $error("request taken while converting");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .digit_valid (digit_valid),
    .digit_stall (digit_stall),
    .digit_char  (digit_char),
    .last        (last)
);

### tb/tb_binary_to_decimal_ascii_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_to_decimal_ascii_core: directed and random 64-bit values,
// with every decimal digit checked against a behavioral divide-by-ten predictor.
// Depends on b2da_pkg and binary_to_decimal_ascii_core.
module tb_binary_to_decimal_ascii_core;

    localparam int VALUE_BITS    = b2da_pkg::DEFAULT_VALUE_BITS;
    localparam int DIGITS        = b2da_pkg::num_digits(VALUE_BITS);
    localparam int CONV_CYCLES   = VALUE_BITS + DIGITS + 1;
    localparam int MAX_WAIT      = 10;
    localparam int RANDOM_VALUES = 450;
    localparam int CYCLE_LIMIT   = 1000 * (RANDOM_VALUES + 25) + 20000;

    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } digit_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          value_valid = 1'b0;
    logic                          value_stall;
    logic [b2da_pkg::VALUE_W-1:0]  value       = '0;
    logic                          digit_valid;
    logic                          digit_stall = 1'b0;
    logic [b2da_pkg::CHAR_W-1:0]   digit_char;
    logic                          last;

    logic [b2da_pkg::VALUE_W-1:0]  pending_values[$];
    digit_t                        due_digits[$];
    int                            mismatches  = 0;
    int                            cycle_count = 0;
    int                            send_gap    = 0;
    int                            recv_hold   = 0;
    bit                            send_calm   = 1'b0;
    bit                            recv_calm   = 1'b0;

    binary_to_decimal_ascii_core #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_valid(value_valid),
        .value_stall(value_stall),
        .value      (value),
        .digit_valid(digit_valid),
        .digit_stall(digit_stall),
        .digit_char (digit_char),
        .last       (last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Expected ASCII digits of one request, most significant first.
    function automatic void push_decimal_digits(input logic [b2da_pkg::VALUE_W-1:0] raw);
        logic [b2da_pkg::VALUE_W-1:0] v;
        logic [3:0]                   rev[DIGITS];
        int                           n;
        digit_t                       d;
        v = raw;
        if (VALUE_BITS < b2da_pkg::VALUE_W)
            v = raw & ({b2da_pkg::VALUE_W{1'b1}} >> (b2da_pkg::VALUE_W - VALUE_BITS));
        n = 0;
        do
        begin
            rev[n] = 4'(v % 64'd10);
            v      = v / 64'd10;
            n++;
        end
        while (v != 0 && n < DIGITS);
        for (int k = 0; k < n; k++)
        begin
            d.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev[n - 1 - k]);
            d.last = (k == n - 1);
            due_digits.push_back(d);
        end
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 15) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [b2da_pkg::VALUE_W-1:0] pow10(input int k);
        logic [b2da_pkg::VALUE_W-1:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            value_valid <= 1'b0;
            value       <= '0;
            send_gap    <= 0;
        end
        else if (!(value_valid && value_stall))
        begin
            n = send_gap;
            if (value_valid)
            begin
                push_decimal_digits(value);
                n = draw_wait(send_calm);
            end
            if (n == 0 && pending_values.size() > 0)
            begin
                value_valid <= 1'b1;
                value       <= pending_values.pop_front();
            end
            else
            begin
                value_valid <= 1'b0;
                if (n > 0)
                    n = n - 1;
            end
            send_gap <= n;
        end
    end

    // Digit monitor
    always @(posedge clk or negedge rst_n)
    begin
        int     n;
        digit_t want;
        if (!rst_n)
        begin
            digit_stall <= 1'b0;
            recv_hold   <= 0;
        end
        else
        begin
            if (digit_valid && !digit_stall)
            begin
                if (due_digits.size() == 0)
                    report_mismatch($sformatf("unexpected digit %0d last %0b", digit_char, last));
                else
                begin
                    want = due_digits.pop_front();
                    if (digit_char !== want.ch)
                        report_mismatch($sformatf("digit_char %0d, want %0d",
                                                  digit_char, want.ch));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
                end
                n = draw_wait(recv_calm);
            end
            else
                n = (recv_hold > 0) ? recv_hold - 1 : 0;
            recv_hold   <= n;
            digit_stall <= (n != 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_binary_to_decimal_ascii_core: errors");
            $finish;
        end
    end

    initial
    begin
        logic [b2da_pkg::VALUE_W-1:0] v;
        int                           k;

        pending_values.push_back(64'd0);
        pending_values.push_back(64'd1);
        pending_values.push_back(64'd9);
        pending_values.push_back(64'd10);
        pending_values.push_back(64'd99);
        pending_values.push_back(64'd100);
        pending_values.push_back(64'd1234567890);
        pending_values.push_back(64'd12345678901234567890);
        pending_values.push_back({b2da_pkg::VALUE_W{1'b1}});
        pending_values.push_back({1'b1, {(b2da_pkg::VALUE_W-1){1'b0}}});
        pending_values.push_back({1'b0, {(b2da_pkg::VALUE_W-1){1'b1}}});
        pending_values.push_back(pow10(19));
        pending_values.push_back(pow10(19) - 64'd1);
        pending_values.push_back(pow10(18));
        pending_values.push_back(pow10(10) - 64'd1);
        pending_values.push_back(64'h5555_5555_5555_5555);
        pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_values.push_back(64'h0000_0000_FFFF_FFFF);
        pending_values.push_back(64'hFFFF_FFFF_0000_0000);
        pending_values.push_back(64'd1000000000000000001);

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            k = $urandom_range(0, 19);
            case ($urandom_range(0, 4))
                0: v = {$urandom, $urandom};
                1: v = {$urandom, $urandom} >> $urandom_range(0, b2da_pkg::VALUE_W - 1);
                2: v = pow10(k) - 64'd1 + 64'($urandom_range(0, 2));
                3: v = 64'($urandom_range(0, 1000));
                default: v = {b2da_pkg::VALUE_W{1'b1}} >> $urandom_range(0, b2da_pkg::VALUE_W - 1);
            endcase
            pending_values.push_back(v);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() > 0 || value_valid || due_digits.size() > 0)
            @(posedge clk);
        repeat (2 * CONV_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_binary_to_decimal_ascii_core: clean");
        else
            $display("tb_binary_to_decimal_ascii_core: errors");
        $finish;
    end

endmodule

### filelist.f
src/b2da_pkg.sv
src/b2da_bcd_shift.sv
src/binary_to_decimal_ascii_core.sv
src/b2da_checker.sv
tb/tb_binary_to_decimal_ascii_core.sv
